/* sv/clt_pkg.sv */
// Shared types and constants for the Coleman-Liau text grader.
// Used by the channel interfaces, the counter unit and the top level.
package clt_pkg;

    // Counter width and width of the count fields on the result channel
    localparam int COUNT_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int BAND_W      = 5;

    // Arithmetic widths: products and the signed index numerator
    localparam int PROD_W = COUNT_WIDTH + 12;
    localparam int ACC_W  = COUNT_WIDTH + 16;
    localparam int K_W    = 12;

    // Index weights, scaled by 10000 (letters, sentences) and 100 (words)
    localparam logic [K_W-1:0] K_LETTER   = 12'd588;
    localparam logic [K_W-1:0] K_SENTENCE = 12'd2960;
    localparam logic [K_W-1:0] K_WORD     = 12'd1580;
    localparam logic [K_W-1:0] K_DEN      = 12'd100;

    localparam logic [BAND_W-1:0] BAND_ZERO = 5'd0;
    localparam logic [BAND_W-1:0] BAND_TOP  = 5'd16;

    // Character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] letters;
        logic [COUNT_WIDTH-1:0] words;
        logic [COUNT_WIDTH-1:0] sentences;
    } t_counts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_LET,
        ST_A_LET,
        ST_P_SEN,
        ST_A_SEN,
        ST_P_WRD,
        ST_A_WRD,
        ST_P_DEN,
        ST_A_DEN,
        ST_CHK16,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

/* sv/clt_if.sv */
// Valid/ready channels of the text grader: text bytes in, grades out.
// Depends on clt_pkg for field widths.
interface clt_in_if import clt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, text_byte, byte_present, end_of_text, input ready);
    modport sink   (input valid, text_byte, byte_present, end_of_text, output ready);
endinterface

interface clt_out_if import clt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FIELD_W-1:0] letter_count;
    logic [FIELD_W-1:0] word_count;
    logic [FIELD_W-1:0] sentence_count;
    logic [BAND_W-1:0]  grade_band;
    logic               empty_text;

    modport source (output valid, letter_count, word_count, sentence_count, grade_band,
                    empty_text, input ready);
    modport sink   (input valid, letter_count, word_count, sentence_count, grade_band,
                    empty_text, output ready);
endinterface

/* sv/clt_count.sv */
// Byte classifier and saturating letter, word and sentence counters.
// Depends on clt_pkg.
module clt_count import clt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_present,
    input  logic       i_clear,
    output t_counts    o_counts
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    t_counts r_counts, n_counts;
    logic    r_in_word, n_in_word;
    logic    w_letter, w_mark, w_blank;

    // Classify the incoming byte
    always_comb begin
        w_letter = (i_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        w_mark   = (i_byte == CH_DOT) || (i_byte == CH_BANG) || (i_byte == CH_QUERY);
        w_blank  = (i_byte == CH_SPACE) || (i_byte inside {[CH_TAB:CH_CR]});
    end

    // Clear or advance the counters, stopping at all ones
    always_comb begin
        n_counts  = r_counts;
        n_in_word = r_in_word;
        if (i_clear) begin
            n_counts  = '0;
            n_in_word = 1'b0;
        end else if (i_take && i_present) begin
            if (w_letter && (r_counts.letters != CNT_MAX)) begin
                n_counts.letters = r_counts.letters + 1'b1;
            end
            if (w_mark && (r_counts.sentences != CNT_MAX)) begin
                n_counts.sentences = r_counts.sentences + 1'b1;
            end
            if (w_blank) begin
                n_in_word = 1'b0;
            end else if (!r_in_word) begin
                n_in_word = 1'b1;
                if (r_counts.words != CNT_MAX) begin
                    n_counts.words = r_counts.words + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts  <= '0;
            r_in_word <= 1'b0;
        end else begin
            r_counts  <= n_counts;
            r_in_word <= n_in_word;
        end
    end

    assign o_counts = r_counts;

endmodule

/* sv/clt_alu.sv */
// Shared adder/subtractor used by the grade sequencer for its add, subtract and compare steps.
// Depends on clt_pkg.
module clt_alu import clt_pkg::*; (
    input  logic [ACC_W-1:0] i_a,
    input  logic [ACC_W-1:0] i_b,
    input  logic             i_sub,
    output logic [ACC_W-1:0] o_res,
    output logic             o_neg
);

    // Add or subtract; the top bit gives the sign of the signed result
    always_comb begin
        if (i_sub) begin
            o_res = i_a - i_b;
        end else begin
            o_res = i_a + i_b;
        end
        o_neg = o_res[ACC_W-1];
    end

endmodule

/* sv/coleman_liau_text_grader.sv */
// Coleman-Liau text grader: counts letters, words and sentences per text.
// Bytes are taken one per cycle while the grader is idle. The end-of-text item
// starts the grade sequence on one shared adder: numerator, range check and
// division (a text with no words goes straight to the result), plus any wait
// for a full output register; the result is valid the cycle after and the input is not ready meanwhile.
// Synchronous active-low reset clears counters, sequencer and result valid.
module coleman_liau_text_grader import clt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clt_in_if.sink    i_in,
    clt_out_if.source o_out
);

    t_state r_state, n_state;

    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]  r_prod, n_prod;
    logic [ACC_W-1:0]  r_dvs, n_dvs;
    logic [1:0]        r_bit, n_bit;
    logic [3:0]        r_q, n_q;
    logic [BAND_W-1:0] r_band, n_band;
    logic              r_empty, n_empty;

    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_out_let, n_out_let;
    logic [FIELD_W-1:0] r_out_wrd, n_out_wrd;
    logic [FIELD_W-1:0] r_out_sen, n_out_sen;
    logic [BAND_W-1:0]  r_out_band, n_out_band;
    logic               r_out_empty, n_out_empty;

    logic                   w_take;
    logic                   w_clear;
    t_counts                w_counts;
    logic [K_W-1:0]         w_mul_k;
    logic [COUNT_WIDTH-1:0] w_mul_v;
    logic [PROD_W-1:0]      w_mul;
    logic [ACC_W-1:0]       w_alu_a, w_alu_b, w_alu_res;
    logic                   w_alu_sub, w_alu_neg;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_take     = i_in.valid && i_in.ready;

    clt_count u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_byte    (i_in.text_byte),
        .i_present (i_in.byte_present),
        .i_clear   (w_clear),
        .o_counts  (w_counts)
    );

    clt_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_res (w_alu_res),
        .o_neg (w_alu_neg)
    );

    // Constant weight times a count; registered before the adder uses it
    assign w_mul = PROD_W'(w_mul_k) * PROD_W'(w_mul_v);

    // Sequencer: build the numerator, then a short restoring division
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_dvs       = r_dvs;
        n_bit       = r_bit;
        n_q         = r_q;
        n_band      = r_band;
        n_empty     = r_empty;
        n_out_valid = r_out_valid;
        n_out_let   = r_out_let;
        n_out_wrd   = r_out_wrd;
        n_out_sen   = r_out_sen;
        n_out_band  = r_out_band;
        n_out_empty = r_out_empty;
        w_clear     = 1'b0;
        w_mul_k     = '0;
        w_mul_v     = '0;
        w_alu_a     = '0;
        w_alu_b     = '0;
        w_alu_sub   = 1'b0;

        // Drop the result once transferred
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_take && i_in.end_of_text) begin
                    n_state = ST_P_LET;
                end
            end
            ST_P_LET: begin
                w_mul_k = K_LETTER;
                w_mul_v = w_counts.letters;
                n_prod  = ACC_W'(w_mul);
                if (w_counts.words == '0) begin
                    n_empty = 1'b1;
                    n_band  = BAND_ZERO;
                    n_state = ST_DONE;
                end else begin
                    n_empty = 1'b0;
                    n_state = ST_A_LET;
                end
            end
            ST_A_LET: begin
                w_alu_b = r_prod;
                n_acc   = w_alu_res;
                n_state = ST_P_SEN;
            end
            ST_P_SEN: begin
                w_mul_k = K_SENTENCE;
                w_mul_v = w_counts.sentences;
                n_prod  = ACC_W'(w_mul);
                n_state = ST_A_SEN;
            end
            ST_A_SEN: begin
                w_alu_a   = r_acc;
                w_alu_b   = r_prod;
                w_alu_sub = 1'b1;
                n_acc     = w_alu_res;
                n_state   = ST_P_WRD;
            end
            ST_P_WRD: begin
                w_mul_k = K_WORD;
                w_mul_v = w_counts.words;
                n_prod  = ACC_W'(w_mul);
                n_state = ST_A_WRD;
            end
            ST_A_WRD: begin
                w_alu_a   = r_acc;
                w_alu_b   = r_prod;
                w_alu_sub = 1'b1;
                n_acc     = w_alu_res;
                n_state   = ST_P_DEN;
            end
            ST_P_DEN: begin
                w_mul_k = K_DEN;
                w_mul_v = w_counts.words;
                n_prod  = ACC_W'(w_mul);
                n_state = ST_A_DEN;
            end
            ST_A_DEN: begin
                // A negative numerator always rounds to a grade below one
                if (r_acc[ACC_W-1]) begin
                    n_band  = BAND_ZERO;
                    n_state = ST_DONE;
                end else begin
                    // Dividend 2*num + den, divisor 2*den
                    w_alu_a = r_acc << 1;
                    w_alu_b = r_prod;
                    n_acc   = w_alu_res;
                    n_dvs   = r_prod << 1;
                    n_state = ST_CHK16;
                end
            end
            ST_CHK16: begin
                w_alu_a   = r_acc;
                w_alu_b   = r_dvs << 4;
                w_alu_sub = 1'b1;
                if (!w_alu_neg) begin
                    n_band  = BAND_TOP;
                    n_state = ST_DONE;
                end else begin
                    n_bit   = 2'd3;
                    n_q     = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // One quotient bit a cycle, most significant first
                w_alu_a   = r_acc;
                w_alu_b   = r_dvs << r_bit;
                w_alu_sub = 1'b1;
                if (!w_alu_neg) begin
                    n_acc        = w_alu_res;
                    n_q[r_bit]   = 1'b1;
                end
                if (r_bit == 2'd0) begin
                    n_band  = BAND_W'(n_q);
                    n_state = ST_DONE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free, then clear counters
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_let   = FIELD_W'(w_counts.letters);
                    n_out_wrd   = FIELD_W'(w_counts.words);
                    n_out_sen   = FIELD_W'(w_counts.sentences);
                    n_out_band  = r_band;
                    n_out_empty = r_empty;
                    w_clear     = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and result payload
    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_dvs       <= n_dvs;
        r_bit       <= n_bit;
        r_q         <= n_q;
        r_band      <= n_band;
        r_empty     <= n_empty;
        r_out_let   <= n_out_let;
        r_out_wrd   <= n_out_wrd;
        r_out_sen   <= n_out_sen;
        r_out_band  <= n_out_band;
        r_out_empty <= n_out_empty;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.letter_count   = r_out_let;
    assign o_out.word_count     = r_out_wrd;
    assign o_out.sentence_count = r_out_sen;
    assign o_out.grade_band     = r_out_band;
    assign o_out.empty_text     = r_out_empty;

endmodule
